>>> src/bds_pkg.sv
// shared types and constants for the baud divisor search block
// no dependencies; imported by every module of the block
package bds_pkg;

    // field widths of the transaction payloads
    localparam int FIELD_W = 27;
    localparam int EXP_W   = 4;
    localparam int COUNT_W = 9;

    // search limits and special answers
    localparam int MAX_PRESCALE_LOG2_DEF = 9;
    localparam int COUNT_LIMIT           = 256;
    localparam int SLOW_COUNT            = 255;
    localparam int CLOCK_RESET           = 32000000;

    // one search result as handed from the sequencer to the output register
    typedef struct packed {
        logic [EXP_W-1:0]   exponent;
        logic [COUNT_W-1:0] count;
        logic               slow;
    } t_result;

endpackage

>>> src/bds_div.sv
// restoring serial divider, one quotient bit per cycle
// depends on bds_pkg; shared by every prescale trial of bds_ctrl
module bds_div #(
    parameter int DIV_W = bds_pkg::FIELD_W + bds_pkg::MAX_PRESCALE_LOG2_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [bds_pkg::FIELD_W-1:0] i_dividend,
    input  logic [DIV_W-1:0]            i_divisor,
    output logic                        o_done,
    output logic [bds_pkg::FIELD_W-1:0] o_quotient,
    output logic [bds_pkg::FIELD_W-1:0] o_remainder
);
    import bds_pkg::*;

    localparam int CNT_W = $clog2(FIELD_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [FIELD_W-1:0] r_rem;
    logic [FIELD_W-1:0] r_quo;
    logic [DIV_W-1:0]   r_div;

    logic [FIELD_W:0]   shifted;
    logic [DIV_W-1:0]   shifted_x;
    logic               ge;
    logic [DIV_W-1:0]   diff;
    logic [FIELD_W-1:0] n_rem;

    // one compare-and-subtract step
    always_comb begin
        shifted   = {r_rem, r_quo[FIELD_W-1]};
        shifted_x = DIV_W'(shifted);
        ge        = (shifted_x >= r_div);
        diff      = shifted_x - r_div;
        n_rem     = ge ? diff[FIELD_W-1:0] : shifted[FIELD_W-1:0];
    end

    // step sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(FIELD_W - 1);
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[FIELD_W-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

    // done only closes a running division
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a running division");

    // no new division while one is running
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_start)
        else $error("divider started while busy");

    // remainder is reduced below a nonzero divisor
    a_rem_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_div != '0) |-> (DIV_W'(r_rem) < r_div))
        else $error("divider remainder not below divisor");

endmodule

>>> src/bds_ctrl.sv
// sequencer over prescale trials, rounding and result hold
// depends on bds_pkg; drives the shared divider bds_div
module bds_ctrl #(
    parameter int MAX_PRESCALE_LOG2 = bds_pkg::MAX_PRESCALE_LOG2_DEF,
    parameter int DIV_W             = bds_pkg::FIELD_W + bds_pkg::MAX_PRESCALE_LOG2_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [bds_pkg::FIELD_W-1:0] i_target_baud,
    output logic                        o_div_start,
    output logic [DIV_W-1:0]            o_div_divisor,
    input  logic                        i_div_done,
    input  logic [bds_pkg::FIELD_W-1:0] i_div_quotient,
    input  logic [bds_pkg::FIELD_W-1:0] i_div_remainder,
    output logic                        o_res_valid,
    input  logic                        i_res_take,
    output bds_pkg::t_result            o_res
);
    import bds_pkg::*;

    localparam int E_W = $clog2(MAX_PRESCALE_LOG2 + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_HOLD
    } t_state;

    t_state             r_state;
    logic               r_start;
    logic [FIELD_W-1:0] r_target;
    logic [E_W-1:0]     r_e;
    t_result            r_res;

    logic               q_fail;
    logic               last_trial;
    logic               round_up;
    t_result            slow_res;

    // trial divisor and decision on the finished quotient
    always_comb begin
        o_div_divisor = DIV_W'(r_target) << r_e;
        q_fail        = ((r_e == '0) && (i_div_quotient > FIELD_W'(1)))
                        || (i_div_quotient > FIELD_W'(COUNT_LIMIT));
        last_trial    = (r_e == E_W'(MAX_PRESCALE_LOG2));
        round_up      = (i_div_quotient != FIELD_W'(COUNT_LIMIT))
                        && (DIV_W'({i_div_remainder, 1'b0}) > o_div_divisor);
        slow_res.exponent = EXP_W'(MAX_PRESCALE_LOG2);
        slow_res.count    = COUNT_W'(SLOW_COUNT);
        slow_res.slow     = 1'b1;
    end

    // search sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_start <= 1'b0;
        end else begin
            r_start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_target <= i_target_baud;
                        r_e      <= '0;
                        if (i_target_baud == '0) begin
                            r_res   <= slow_res;
                            r_state <= S_HOLD;
                        end else begin
                            r_start <= 1'b1;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (i_div_done) begin
                        if (q_fail) begin
                            if (last_trial) begin
                                r_res   <= slow_res;
                                r_state <= S_HOLD;
                            end else begin
                                r_e     <= r_e + 1'b1;
                                r_start <= 1'b1;
                            end
                        end else begin
                            r_res.exponent <= EXP_W'(r_e);
                            r_res.count    <= COUNT_W'(i_div_quotient)
                                              + COUNT_W'(round_up);
                            r_res.slow     <= 1'b0;
                            r_state        <= S_HOLD;
                        end
                    end
                end
                S_HOLD: begin
                    if (i_res_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_div_start = r_start;
    assign o_res_valid = (r_state == S_HOLD);
    assign o_res       = r_res;

    // divider is started only inside a search
    a_start_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |-> (r_state == S_DIV))
        else $error("divider start outside a search");

    // a found count never passes the limit
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOLD && !r_res.slow) |-> (r_res.count <= COUNT_W'(COUNT_LIMIT)))
        else $error("down count above limit");

    // the too-slow answer is the slowest setting
    a_slow_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOLD && r_res.slow) |->
        (r_res.exponent == EXP_W'(MAX_PRESCALE_LOG2)
         && r_res.count == COUNT_W'(SLOW_COUNT)))
        else $error("too-slow result is not the slowest setting");

endmodule

>>> src/baud_divisor_search_core.sv
// baud divisor search: up to MAX_PRESCALE_LOG2+1 trials, each one serial divide on bds_div
// each trial is a start, a load and one step per quotient bit; trials = chosen exponent + 1;
// then the result moves to the output register; every trial runs when no prescaler fits
// one transaction in flight; next input taken the cycle after the result moves to the output
// register; a zero target skips the divider and goes straight to the result hold
// synchronous active-low reset: reference clock back to 32 MHz, pipeline emptied
module baud_divisor_search_core #(
    parameter int MAX_PRESCALE_LOG2 = bds_pkg::MAX_PRESCALE_LOG2_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [bds_pkg::FIELD_W-1:0] i_ref_clock_hz,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [bds_pkg::FIELD_W-1:0] i_target_baud,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [bds_pkg::EXP_W-1:0]   o_prescale_exponent,
    output logic [bds_pkg::COUNT_W-1:0] o_down_count,
    output logic                        o_too_slow
);
    import bds_pkg::*;

    localparam int DIV_W = FIELD_W + MAX_PRESCALE_LOG2;

    logic [FIELD_W-1:0] r_ref_clock_hz;
    logic               r_out_valid;
    t_result            r_out;

    logic               div_start;
    logic [DIV_W-1:0]   div_divisor;
    logic               div_done;
    logic [FIELD_W-1:0] div_quotient;
    logic [FIELD_W-1:0] div_remainder;
    logic               res_valid;
    logic               res_take;
    t_result            res;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_clock_hz <= FIELD_W'(CLOCK_RESET);
        end else if (i_cfg_valid) begin
            r_ref_clock_hz <= i_ref_clock_hz;
        end
    end

    assign o_cfg_ready = 1'b1;

    // shared divider
    bds_div #(
        .DIV_W(DIV_W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (r_ref_clock_hz),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quotient),
        .o_remainder (div_remainder)
    );

    // trial sequencer
    bds_ctrl #(
        .MAX_PRESCALE_LOG2(MAX_PRESCALE_LOG2),
        .DIV_W            (DIV_W)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_target_baud   (i_target_baud),
        .o_div_start     (div_start),
        .o_div_divisor   (div_divisor),
        .i_div_done      (div_done),
        .i_div_quotient  (div_quotient),
        .i_div_remainder (div_remainder),
        .o_res_valid     (res_valid),
        .i_res_take      (res_take),
        .o_res           (res)
    );

    // output register, refilled when empty or when its transaction leaves
    assign res_take = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= res_valid;
            if (res_valid) begin
                r_out <= res;
            end
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_prescale_exponent = r_out.exponent;
    assign o_down_count        = r_out.count;
    assign o_too_slow          = r_out.slow;

endmodule

>>> sim/baud_divisor_search_core_tb.sv
// testbench for baud_divisor_search_core: checks prescale exponent, down count and slow flag
// against an in-bench divisor search over several reference clocks and flow-control patterns
// depends on bds_pkg and baud_divisor_search_core
module baud_divisor_search_core_tb;

    typedef logic [bds_pkg::FIELD_W-1:0] t_field;
    typedef logic [bds_pkg::EXP_W-1:0]   t_exp;
    typedef logic [bds_pkg::COUNT_W-1:0] t_count;

    localparam longint BAUD_MAX    = (64'd1 << bds_pkg::FIELD_W) - 1;
    localparam int     PRESCALE_MX = bds_pkg::MAX_PRESCALE_LOG2_DEF;
    localparam int     CYCLE_LIMIT = 4000000;
    localparam int     DRAIN_WAIT  = 400;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [bds_pkg::FIELD_W-1:0] i_ref_clock_hz = t_field'(bds_pkg::CLOCK_RESET);
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic [bds_pkg::FIELD_W-1:0] i_target_baud = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic [bds_pkg::EXP_W-1:0]   o_prescale_exponent;
    logic [bds_pkg::COUNT_W-1:0] o_down_count;
    logic                        o_too_slow;

    // bench copy of the reference clock register
    logic [bds_pkg::FIELD_W-1:0] ref_hz = t_field'(bds_pkg::CLOCK_RESET);

    logic [bds_pkg::FIELD_W-1:0] queued_bauds[$];
    bds_pkg::t_result            pending_divisors[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int cycles         = 0;

    baud_divisor_search_core uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_ref_clock_hz      (i_ref_clock_hz),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_target_baud       (i_target_baud),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_prescale_exponent (o_prescale_exponent),
        .o_down_count        (o_down_count),
        .o_too_slow          (o_too_slow)
    );

    always #10 i_clk = ~i_clk;

    // divisor search: first fitting power-of-two prescaler, then round to nearest
    function automatic bds_pkg::t_result divisor_for(input logic [bds_pkg::FIELD_W-1:0] clk_hz,
                                                      input logic [bds_pkg::FIELD_W-1:0] baud);
        longint unsigned  clk64;
        longint unsigned  tgt;
        longint unsigned  pre;
        longint unsigned  q;
        longint unsigned  below;
        longint unsigned  above;
        int               e;
        bit               hit;
        bds_pkg::t_result r;
        clk64 = clk_hz;
        tgt   = baud;
        hit   = 1'b0;
        q     = 0;
        pre   = 1;
        e     = 0;
        if (tgt != 0) begin
            for (e = 0; e <= PRESCALE_MX; e++) begin
                pre = 64'd1 << e;
                q   = clk64 / (pre * tgt);
                // divide-by-one stage only when the count is at most one
                if (e == 0 && q > 1)
                    continue;
                if (q <= bds_pkg::COUNT_LIMIT) begin
                    hit = 1'b1;
                    break;
                end
            end
        end
        if (!hit) begin
            r.exponent = t_exp'(PRESCALE_MX);
            r.count    = t_count'(bds_pkg::SLOW_COUNT);
            r.slow     = 1'b1;
        end else begin
            // round up only on a strictly smaller error, never past the limit
            if (q != bds_pkg::COUNT_LIMIT) begin
                below = clk64 - q * pre * tgt;
                above = tgt * (q + 1) * pre - clk64;
                if (below > above)
                    q = q + 1;
            end
            r.exponent = e[bds_pkg::EXP_W-1:0];
            r.count    = q[bds_pkg::COUNT_W-1:0];
            r.slow     = 1'b0;
        end
        return r;
    endfunction

    // clamp a candidate rate into the legal target range
    function automatic logic [bds_pkg::FIELD_W-1:0] fit_baud(input longint v);
        if (v < 1)
            return t_field'(1);
        if (v > BAUD_MAX)
            return BAUD_MAX[bds_pkg::FIELD_W-1:0];
        return v[bds_pkg::FIELD_W-1:0];
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("%0t ERROR %s", $time, msg);
        mismatch_count++;
    endtask

    // rates around the prescaler and rounding boundaries of the given clock
    task automatic push_edge_bauds(input longint clk);
        queued_bauds.push_back(fit_baud(1));
        queued_bauds.push_back(fit_baud(BAUD_MAX));
        queued_bauds.push_back(fit_baud(64'd1 << 26));
        queued_bauds.push_back(fit_baud(27'h2AAAAAA));
        queued_bauds.push_back(fit_baud(27'h5555555));
        queued_bauds.push_back(fit_baud(clk));
        queued_bauds.push_back(fit_baud(clk + 1));
        queued_bauds.push_back(fit_baud(clk - 1));
        queued_bauds.push_back(fit_baud(clk / 2));
        queued_bauds.push_back(fit_baud(2 * clk));
        queued_bauds.push_back(fit_baud(2 * clk - 1));
        queued_bauds.push_back(fit_baud(2 * clk + 1));
        queued_bauds.push_back(fit_baud(clk / 256));
        queued_bauds.push_back(fit_baud(clk / 512));
        queued_bauds.push_back(fit_baud(clk / 514));
        queued_bauds.push_back(fit_baud(clk / (512 * 256)));
        queued_bauds.push_back(fit_baud(clk / (512 * 256) + 1));
        queued_bauds.push_back(fit_baud(clk / (512 * 257)));
        queued_bauds.push_back(fit_baud(62256));
        queued_bauds.push_back(fit_baud(115200));
        queued_bauds.push_back(fit_baud(300));
    endtask

    // random rates: full range, log spread, near boundaries, and deep slow searches
    task automatic push_random_bauds(input int n);
        int     kind;
        int     w;
        int     e;
        int     c;
        longint v;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(0, 3);
            case (kind)
                0: begin
                    v = $urandom_range(1, BAUD_MAX);
                end
                1: begin
                    w = $urandom_range(1, bds_pkg::FIELD_W);
                    v = ($urandom & ((32'd1 << w) - 1)) | (32'd1 << (w - 1));
                end
                2: begin
                    e = $urandom_range(0, PRESCALE_MX);
                    case ($urandom_range(0, 4))
                        0: c = 1;
                        1: c = 2;
                        2: c = 255;
                        3: c = 256;
                        default: c = 257;
                    endcase
                    v = longint'(ref_hz) / ((longint'(1) << e) * c);
                    v = v + $urandom_range(0, 4) - 2;
                end
                default: begin
                    v = $urandom_range(1, 2000);
                end
            endcase
            queued_bauds.push_back(fit_baud(v));
        end
    endtask

    // wait until every queued rate is taken and every result has come back
    task automatic wait_drained();
        while (queued_bauds.size() != 0 || i_in_valid || pending_divisors.size() != 0)
            @(posedge i_clk);
    endtask

    // register write, only with the block idle
    task automatic write_ref_clock(input logic [bds_pkg::FIELD_W-1:0] hz);
        wait_drained();
        @(posedge i_clk);
        i_cfg_valid    <= 1'b1;
        i_ref_clock_hz <= hz;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        ref_hz = hz;
        i_cfg_valid <= 1'b0;
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                pending_divisors.push_back(divisor_for(ref_hz, i_target_baud));
            if (!i_in_valid || !o_in_stall) begin
                if (queued_bauds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_target_baud <= queued_bauds.pop_front();
                    i_in_valid    <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        bds_pkg::t_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_divisors.size() == 0) begin
                    flag_mismatch("result transaction with nothing pending");
                end else begin
                    want = pending_divisors.pop_front();
                    if (o_prescale_exponent !== want.exponent)
                        flag_mismatch($sformatf("prescale_exponent %0d, wanted %0d",
                                                o_prescale_exponent, want.exponent));
                    if (o_down_count !== want.count)
                        flag_mismatch($sformatf("down_count %0d, wanted %0d",
                                                o_down_count, want.count));
                    if (o_too_slow !== want.slow)
                        flag_mismatch($sformatf("too_slow %0b, wanted %0b",
                                                o_too_slow, want.slow));
                end
            end
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // run-time limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("baud_divisor_search_core: mismatch");
            $finish;
        end
    end

    // phases: reset clock, extremes, then random, uart crystal and reset clocks with varied flow control
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset clock, directed rates, no idling
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        push_edge_bauds(ref_hz);

        // fastest clock, sender idle
        write_ref_clock(BAUD_MAX[bds_pkg::FIELD_W-1:0]);
        send_idle_pct  = 69;
        recv_stall_pct = 0;
        push_edge_bauds(ref_hz);
        push_random_bauds(300);

        // slowest clock, receiver stalling
        write_ref_clock(t_field'(1));
        send_idle_pct  = 0;
        recv_stall_pct = 69;
        push_edge_bauds(ref_hz);
        push_random_bauds(200);

        // random clock, light idling on both sides
        write_ref_clock(t_field'($urandom_range(1, BAUD_MAX)));
        send_idle_pct  = 6;
        recv_stall_pct = 6;
        push_random_bauds(350);

        // common uart crystal, no idling
        write_ref_clock(t_field'(1843200));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        push_random_bauds(300);

        // back to the reset value, receiver stalling
        write_ref_clock(t_field'(bds_pkg::CLOCK_RESET));
        send_idle_pct  = 0;
        recv_stall_pct = 69;
        push_random_bauds(300);

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("baud_divisor_search_core: match");
        end else begin
            $display("baud_divisor_search_core: mismatch");
        end
        $finish;
    end

endmodule
